// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Defaults for the window depth and the sample width, the reset value of the
// window size register, and the status and link records passed between cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default deepest window and sample width
  localparam int MaxWindowDef  = 64;
  localparam int SampleBitsDef = 32;

  // Window size register
  localparam int              CfgBits     = 7;
  localparam logic [CfgBits-1:0] WindowReset = 7'd3;

  // What a cell reports about itself
  typedef struct packed {
    logic vld;   // cell holds a sample of the window
    logic gt;    // cell value above the new item, or cell empty
    logic ev;    // cell holds the oldest sample and leaves on this item
  } swm_stat_t;

  // What a cell learns about a neighbor
  typedef struct packed {
    logic vld;   // neighbor holds a sample
    logic gt;    // neighbor value above the new item, or neighbor empty
    logic le;    // evicted cell sits at or below the neighbor
  } swm_link_t;

endpackage

// ===== hdl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample and its age. On each item it keeps its value, takes the
// neighbor's value from above or below, or takes the new sample, so that the
// row stays sorted after the oldest sample leaves and the new one enters.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SW = swm_pkg::SampleBitsDef,
  parameter int AW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    clear_i,
  input  logic                    full_i,
  input  logic signed [SW-1:0]    x_i,
  input  logic        [AW-1:0]    weff_m1_i,
  input  logic                    le_i,
  input  swm_pkg::swm_link_t      lo_link_i,
  input  logic signed [SW-1:0]    lo_val_i,
  input  logic        [AW-1:0]    lo_age_i,
  input  swm_pkg::swm_link_t      hi_link_i,
  input  logic signed [SW-1:0]    hi_val_i,
  input  logic        [AW-1:0]    hi_age_i,
  output swm_pkg::swm_stat_t      stat_o,
  output logic signed [SW-1:0]    val_o,
  output logic        [AW-1:0]    age_o
);
  import swm_pkg::*;

  logic signed [SW-1:0] val_q, val_d;
  logic        [AW-1:0] age_q, age_d;
  logic                 vld_q, vld_d;

  logic                 gt;
  logic                 gp_own, gp_lo;
  logic signed [SW-1:0] rv_own, rv_lo;
  logic        [AW-1:0] ra_own, ra_lo;

  // Own compare against the new item; an empty cell counts as above it
  assign gt = !vld_q || (val_q > x_i);

  // Row with the evicted sample removed: this slot and the one below it
  always_comb begin
    if (!le_i) begin
      gp_own = gt;
      rv_own = val_q;
      ra_own = age_q;
    end else begin
      gp_own = hi_link_i.gt;
      rv_own = hi_val_i;
      ra_own = hi_age_i;
    end
    if (!lo_link_i.le) begin
      gp_lo = lo_link_i.gt;
      rv_lo = lo_val_i;
      ra_lo = lo_age_i;
    end else begin
      gp_lo = gt;
      rv_lo = val_q;
      ra_lo = age_q;
    end
  end

  // Insert the new item into the reduced row
  always_comb begin
    if (!gp_own) begin
      val_d = rv_own;
      age_d = ra_own + AW'(1);
    end else if (!gp_lo) begin
      val_d = x_i;
      age_d = '0;
    end else begin
      val_d = rv_lo;
      age_d = ra_lo + AW'(1);
    end
  end

  // Occupancy grows from the bottom while filling, fixed once full
  always_comb begin
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (load_i && !full_i) begin
      vld_d = vld_q || lo_link_i.vld;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Sample and age
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign stat_o.vld = vld_q;
  assign stat_o.gt  = gt;
  assign stat_o.ev  = full_i && vld_q && (age_q == weff_m1_i);
  assign val_o      = val_q;
  assign age_o      = age_q;

endmodule

// ===== hdl/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top: running lower median over a sliding window
// Sorted row of cells; each item evicts the oldest sample and inserts the new
// one in the same cycle, and the lower median is read from the row.
// ----------------------------------------------------------------------------
// The filter takes one sample per clock unless the input stalls. The window
// is a row of MAX_WINDOW cells kept in ascending order; every cell holds a
// sample and its age and compares it with the incoming sample, so eviction
// of the oldest sample and insertion of the new one happen together in the
// cell row. The median of the updated row moves into the output register
// once that is free and waits there; input stalls only when a finished
// median is waiting there and the next one is ready behind it. The first
// window_size-1 samples after reset or after a write to window_size produce
// no median; window_size 0 acts as 1 and sizes above MAX_WINDOW saturate.
module sliding_window_median_top #(
  parameter int MAX_WINDOW  = swm_pkg::MaxWindowDef,
  parameter int SAMPLE_BITS = swm_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   median_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swm_pkg::CfgBits-1:0]     window_size_i
);
  import swm_pkg::*;

  localparam int N  = MAX_WINDOW;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [CfgBits-1:0]     ws_q;
  logic [CW-1:0]          fill_q, fill_d;
  logic [CW-1:0]          weff;
  logic [AW-1:0]          weff_m1, mid_idx;
  logic                   full, produce, load, clear;
  logic                   pend_q, out_load;
  logic                   out_valid_q;
  logic signed [SAMPLE_BITS-1:0] med_q;

  swm_stat_t                     stat   [N];
  logic signed [SAMPLE_BITS-1:0] cval   [N];
  logic        [AW-1:0]          cage   [N];
  logic        [N-1:0]           evv;
  logic        [N-1:0]           le;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign clear       = cfg_valid_i;
  assign in_ready_o  = !(pend_q && out_valid_q && !out_ready_i);
  assign load        = in_valid_i && in_ready_o;

  // Effective window length
  always_comb begin
    if (ws_q == '0) begin
      weff = CW'(1);
    end else if (int'(ws_q) > MAX_WINDOW) begin
      weff = CW'(MAX_WINDOW);
    end else begin
      weff = CW'(ws_q);
    end
  end
  assign weff_m1 = AW'(weff - CW'(1));
  assign mid_idx = weff_m1 >> 1;

  // Fill tracking
  assign full    = (fill_q == weff);
  assign produce = full || ((fill_q + CW'(1)) == weff);

  always_comb begin
    if (clear) begin
      fill_d = '0;
    end else if (load && !full) begin
      fill_d = fill_q + CW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WindowReset;
      fill_q <= '0;
    end else begin
      if (clear) begin
        ws_q <= window_size_i;
      end
      fill_q <= fill_d;
    end
  end

  // Cell row
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam logic [N-1:0] BelowMask = {N{1'b1}} >> (N - 1 - k);
    swm_link_t                     lo_link, hi_link;
    logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic        [AW-1:0]          lo_age, hi_age;

    assign evv[k] = stat[k].ev;
    assign le[k]  = |(evv & BelowMask);

    if (k == 0) begin : g_lo_edge
      assign lo_link = '{vld: 1'b1, gt: 1'b0, le: 1'b0};
      assign lo_val  = '0;
      assign lo_age  = '0;
    end else begin : g_lo_nb
      assign lo_link = '{vld: stat[k-1].vld, gt: stat[k-1].gt, le: le[k-1]};
      assign lo_val  = cval[k-1];
      assign lo_age  = cage[k-1];
    end

    if (k == N - 1) begin : g_hi_edge
      assign hi_link = '{vld: 1'b0, gt: 1'b1, le: 1'b1};
      assign hi_val  = '0;
      assign hi_age  = '0;
    end else begin : g_hi_nb
      assign hi_link = '{vld: stat[k+1].vld, gt: stat[k+1].gt, le: le[k+1]};
      assign hi_val  = cval[k+1];
      assign hi_age  = cage[k+1];
    end

    swm_cell #(
      .SW (SAMPLE_BITS),
      .AW (AW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .load_i    (load),
      .clear_i   (clear),
      .full_i    (full),
      .x_i       (sample_i),
      .weff_m1_i (weff_m1),
      .le_i      (le[k]),
      .lo_link_i (lo_link),
      .lo_val_i  (lo_val),
      .lo_age_i  (lo_age),
      .hi_link_i (hi_link),
      .hi_val_i  (hi_val),
      .hi_age_i  (hi_age),
      .stat_o    (stat[k]),
      .val_o     (cval[k]),
      .age_o     (cage[k])
    );
  end

  // Median pick from the updated row into the output register
  assign out_load = pend_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        pend_q <= produce;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      med_q <= cval[mid_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = med_q;

endmodule

// ===== hdl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker: port level checks of the sliding window median filter
// Watches the top level's ports; attached to every instance by a bind.
// ----------------------------------------------------------------------------
module swm_checker #(
  parameter int SW = swm_pkg::SampleBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [SW-1:0] median_o
);

  // A waiting median holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_o))
    else $error("median item dropped or changed while stalled");

  // A fresh median follows its accepted item via the cells and output register
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("median item without a preceding sample item");

  // Input stalls only behind a blocked median
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with the output free");

endmodule

bind sliding_window_median_top swm_checker #(
  .SW (SAMPLE_BITS)
) u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .median_o    (median_o)
);
